// File: design/hwg_pkg.sv
package hwg_pkg;

   localparam int RATE_W    = 8;
   localparam int LEVEL_W   = 12;
   localparam int PHASE_W   = 14;
   localparam int LFSR_W    = 16;
   localparam int OFF_W     = 11;
   localparam int Y_W       = 20;
   localparam int RECIP_W   = 25;
   localparam int RECIP_SHIFT = 30;
   localparam int CSR_IDX_W = 1;

   localparam logic [RATE_W-1:0]  RATE_MIN  = 8'd40;
   localparam logic [RATE_W-1:0]  RATE_MAX  = 8'd200;
   localparam logic [PHASE_W-1:0] BEAT_WRAP = 14'd12000;
   localparam logic [PHASE_W-1:0] RISE_END  = 14'd360;
   localparam logic [PHASE_W-1:0] PULSE_END = 14'd1440;

   localparam logic [LFSR_W-1:0]  LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0]  LFSR_MASK = 16'hB400;

   localparam logic [LEVEL_W-1:0] BASE_RESET = 12'd400;
   localparam logic [LEVEL_W-1:0] PEAK_RESET = 12'd2400;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 12'd4095;

   // Full-scale millivolts, sized for the noise product.
   localparam logic [17:0] FULL_MV = 18'd3300;

   // The rise and fall divide by 360 and 1080; the common factor of 8 is a shift,
   // what remains goes through a reciprocal multiply and a one-step correction.
   localparam logic [LEVEL_W-1:0] RISE_DIV  = 12'd45;
   localparam logic [LEVEL_W-1:0] FALL_DIV  = 12'd135;
   localparam logic [LEVEL_W-1:0] NOISE_DIV = 12'd4095;
   localparam logic [RECIP_W-1:0] RISE_RECIP  = 25'd23860929;
   localparam logic [RECIP_W-1:0] FALL_RECIP  = 25'd7953643;
   localparam logic [RECIP_W-1:0] NOISE_RECIP = 25'd262208;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LEVEL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_LEVEL = 1'd1;

   typedef enum logic [1:0] {
      SEG_RISE,
      SEG_FALL,
      SEG_BASE
   } seg_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic prod;
      logic recip;
      logic fix;
   } cmd_type;

   typedef struct packed {
      logic seg_base;
   } sts_type;

endpackage

// File: design/hwg_ctrl.sv
module hwg_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  hwg_pkg::sts_type sts,
   output hwg_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_PROD,
      ST_RECIP,
      ST_FIX
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = 2'd0;
               state_in = sts.seg_base ? ST_MOD : ST_PROD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            cnt_in       = cnt_ff + 2'd1;
            if (cnt_ff == 2'd1) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = ST_FIX;
         end
         ST_FIX: begin
            // The result register is refilled only once the previous result is gone.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.fix      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/hwg_datapath.sv
module hwg_datapath #(
   parameter int NOISE_SPAN = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hwg_pkg::cmd_type                    cmd,
   output hwg_pkg::sts_type                    sts,
   input  logic [hwg_pkg::RATE_W-1:0]          req_heart_rate,
   input  logic                                csr_valid,
   input  logic [hwg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hwg_pkg::LEVEL_W-1:0]         csr_wdata,
   output logic [hwg_pkg::LEVEL_W-1:0]         rsp_level_mv,
   output logic                                rsp_in_pulse
);

   localparam int REM_W = (NOISE_SPAN > 1) ? $clog2(NOISE_SPAN) : 1;
   localparam int MOD_SHIFT = hwg_pkg::LFSR_W + $clog2(NOISE_SPAN);
   localparam int MOD_PW = hwg_pkg::LFSR_W + MOD_SHIFT;
   localparam logic [MOD_PW-1:0] MOD_RECIP =
      MOD_PW'(((64'd1 << MOD_SHIFT) + 64'(NOISE_SPAN) - 64'd1) / 64'(NOISE_SPAN));
   localparam logic [hwg_pkg::LFSR_W-1:0] MOD_SPAN = hwg_pkg::LFSR_W'(NOISE_SPAN);

   localparam int LW = hwg_pkg::LEVEL_W;
   localparam int PW = hwg_pkg::PHASE_W;
   localparam int YW = hwg_pkg::Y_W;
   localparam int MW = hwg_pkg::RECIP_W;
   localparam int SH = hwg_pkg::RECIP_SHIFT;

   // Configuration and beat state.
   logic [LW-1:0]                base_ff, base_in;
   logic [LW-1:0]                peak_ff, peak_in;
   logic [PW-1:0]                phase_ff, phase_in;
   logic [hwg_pkg::LFSR_W-1:0]   lfsr_ff, lfsr_in;

   // Per-request working registers.
   hwg_pkg::seg_type             seg_ff, seg_in;
   logic [hwg_pkg::OFF_W-1:0]    off_ff, off_in;
   logic [hwg_pkg::LFSR_W-1:0]   sh_ff, sh_in;
   logic [hwg_pkg::LFSR_W-1:0]   mq_ff, mq_in;
   logic [REM_W-1:0]             rem_ff, rem_in;
   logic [YW-1:0]                y_ff, y_in;
   logic [LW-1:0]                q0_ff, q0_in;
   logic [LW-1:0]                level_ff, level_in;
   logic                         pulse_ff, pulse_in;

   logic [hwg_pkg::RATE_W-1:0]   rate;
   logic [PW-1:0]                phase_sum;
   logic [hwg_pkg::LFSR_W-1:0]   lfsr_step;
   logic [LW-1:0]                peak_eff;
   logic [LW-1:0]                diff;
   logic [22:0]                  pulse_prod;
   logic [17:0]                  noise_prod;
   logic [MW-1:0]                recip;
   logic [YW+MW-1:0]             recip_prod;
   logic [LW-1:0]                divisor;
   logic [23:0]                  q0_times_d;
   logic [23:0]                  resid;
   logic [LW-1:0]                quot;
   logic [LW:0]                  noisy_sum;
   logic [MOD_PW-1:0]            mod_prod;
   logic [hwg_pkg::LFSR_W-1:0]   mod_rem;

   assign peak_eff = (peak_ff < base_ff) ? base_ff : peak_ff;
   assign diff     = peak_eff - base_ff;

   assign sts.seg_base = (phase_ff >= hwg_pkg::PULSE_END);

   always_comb begin
      if (req_heart_rate < hwg_pkg::RATE_MIN) begin
         rate = hwg_pkg::RATE_MIN;
      end else if (req_heart_rate > hwg_pkg::RATE_MAX) begin
         rate = hwg_pkg::RATE_MAX;
      end else begin
         rate = req_heart_rate;
      end
      phase_sum = phase_ff + PW'(rate);
      if (phase_sum >= hwg_pkg::BEAT_WRAP) begin
         phase_sum = phase_sum - hwg_pkg::BEAT_WRAP;
      end
   end

   assign lfsr_step = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ hwg_pkg::LFSR_MASK) : (lfsr_ff >> 1);

   // Remainder of the LFSR value by the noise span through a rounded-up reciprocal,
   // exact for every 16-bit value. The first step registers the quotient and the
   // second subtracts quotient times span.
   assign mod_prod = MOD_PW'(sh_ff) * MOD_RECIP;
   assign mod_rem  = sh_ff - mq_ff * MOD_SPAN;

   assign pulse_prod = 23'(diff) * 23'(off_ff);
   assign noise_prod = 18'(rem_ff) * hwg_pkg::FULL_MV;

   always_comb begin
      case (seg_ff)
         hwg_pkg::SEG_RISE: begin
            recip   = hwg_pkg::RISE_RECIP;
            divisor = hwg_pkg::RISE_DIV;
         end
         hwg_pkg::SEG_FALL: begin
            recip   = hwg_pkg::FALL_RECIP;
            divisor = hwg_pkg::FALL_DIV;
         end
         default: begin
            recip   = hwg_pkg::NOISE_RECIP;
            divisor = hwg_pkg::NOISE_DIV;
         end
      endcase
   end

   assign recip_prod = (YW + MW)'(y_ff) * (YW + MW)'(recip);

   // The reciprocal estimate is at most one below the true quotient.
   assign q0_times_d = 24'(q0_ff) * 24'(divisor);
   assign resid      = 24'(y_ff) - q0_times_d;
   assign quot       = (resid >= 24'(divisor)) ? q0_ff + LW'(1) : q0_ff;
   assign noisy_sum  = (LW + 1)'(base_ff) + (LW + 1)'(quot);

   always_comb begin
      base_in  = base_ff;
      peak_in  = peak_ff;
      phase_in = phase_ff;
      lfsr_in  = lfsr_ff;
      seg_in   = seg_ff;
      off_in   = off_ff;
      sh_in    = sh_ff;
      mq_in    = mq_ff;
      rem_in   = rem_ff;
      y_in     = y_ff;
      q0_in    = q0_ff;
      level_in = level_ff;
      pulse_in = pulse_ff;

      if (csr_valid) begin
         unique case (csr_index)
            hwg_pkg::CSR_BASE_LEVEL: base_in = csr_wdata;
            hwg_pkg::CSR_PEAK_LEVEL: peak_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.load) begin
         phase_in = phase_sum;
         rem_in   = '0;
         if (phase_ff < hwg_pkg::RISE_END) begin
            seg_in = hwg_pkg::SEG_RISE;
            off_in = hwg_pkg::OFF_W'(phase_ff);
         end else if (phase_ff < hwg_pkg::PULSE_END) begin
            seg_in = hwg_pkg::SEG_FALL;
            off_in = hwg_pkg::OFF_W'(phase_ff - hwg_pkg::RISE_END);
         end else begin
            seg_in  = hwg_pkg::SEG_BASE;
            lfsr_in = lfsr_step;
            sh_in   = lfsr_step;
         end
      end

      if (cmd.mod_step) begin
         mq_in  = mod_prod[MOD_PW-1:MOD_SHIFT];
         rem_in = mod_rem[REM_W-1:0];
      end

      if (cmd.prod) begin
         if (seg_ff == hwg_pkg::SEG_BASE) begin
            y_in = YW'(noise_prod);
         end else begin
            y_in = pulse_prod[22:3];
         end
      end

      if (cmd.recip) begin
         q0_in = recip_prod[SH+LW-1:SH];
      end

      if (cmd.fix) begin
         case (seg_ff)
            hwg_pkg::SEG_RISE: begin
               level_in = noisy_sum[LW-1:0];
               pulse_in = 1'b1;
            end
            hwg_pkg::SEG_FALL: begin
               level_in = peak_eff - quot;
               pulse_in = 1'b1;
            end
            default: begin
               level_in = noisy_sum[LW] ? hwg_pkg::LEVEL_MAX : noisy_sum[LW-1:0];
               pulse_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= hwg_pkg::BASE_RESET;
         peak_ff  <= hwg_pkg::PEAK_RESET;
         phase_ff <= '0;
         lfsr_ff  <= hwg_pkg::LFSR_SEED;
      end else begin
         base_ff  <= base_in;
         peak_ff  <= peak_in;
         phase_ff <= phase_in;
         lfsr_ff  <= lfsr_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff   <= seg_in;
      off_ff   <= off_in;
      sh_ff    <= sh_in;
      mq_ff    <= mq_in;
      rem_ff   <= rem_in;
      y_ff     <= y_in;
      q0_ff    <= q0_in;
      level_ff <= level_in;
      pulse_ff <= pulse_in;
   end

   assign rsp_level_mv = level_ff;
   assign rsp_in_pulse = pulse_ff;

endmodule

// File: design/heartbeat_waveform_generator.sv
// A request inside the pulse window passes the product, reciprocal and correction steps
// after acceptance; a baseline request first passes through the noise remainder steps.
// A new request is accepted only once the previous one has left the correction step of
// the single datapath, which waits there while an earlier result is still not taken.
// Reset (synchronous): phase 0, noise register 0xACE1, base 400 mV, peak 2400 mV,
// no result pending.
module heartbeat_waveform_generator #(
   parameter int NOISE_SPAN = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [hwg_pkg::RATE_W-1:0]          req_heart_rate,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hwg_pkg::LEVEL_W-1:0]         rsp_level_mv,
   output logic                                rsp_in_pulse,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hwg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hwg_pkg::LEVEL_W-1:0]         csr_wdata
);

   hwg_pkg::cmd_type cmd;
   hwg_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   hwg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hwg_datapath #(
      .NOISE_SPAN (NOISE_SPAN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_heart_rate (req_heart_rate),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_level_mv   (rsp_level_mv),
      .rsp_in_pulse   (rsp_in_pulse)
   );

   // At most one datapath step is commanded in any cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mod_step, cmd.prod, cmd.recip, cmd.fix}))
      else $error("more than one datapath command at once");

   // A new result appears only from the final correction step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.fix))
      else $error("result valid without a finishing step");

   // An accepted request keeps the block busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while the previous one is in flight");

endmodule
